>>> design/bpa_pkg.sv
// Package for the buddy page allocator: default maximum order, status codes
// and sequencer states. No dependencies.
package bpa_pkg;
    localparam int MAX_ORDER_DEF = 10;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_TOO_BIG  = 2'd2,
        ST_IGNORED  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_RM_RD, S_RM_W1, S_RM_W2, S_RM_DONE,
        S_SPLIT, S_PUSH_RD, S_PUSH_W, S_FREE_RD, S_FREE_W,
        S_MRG_RD, S_MRG_CHK, S_MRG_HI, S_FINISH, S_OUT
    } state_t;
endpackage

>>> design/buddy_page_allocator_core.sv
// Buddy page allocator over 2^MAX_ORDER pages, top level.
// Uses bpa_pkg; the page table lives in a single internal synchronous RAM.
//
// An allocation splits the found block once per level down to the requested order,
// pushing each upper half on its list; a free merges with its buddy for as long
// as the buddy is a free head of the same size, up to the top order. The single
// RAM port serializes every table read and write.
// Throughput: one word at a time; the next word is accepted the cycle after the
// result is registered, while that result may still wait on m_axis_tready.
// Reset: the page table is cleared by a pass of 2^MAX_ORDER cycles after
// reset, during which s_axis_tready stays low; page 0 is then the free head.
module buddy_page_allocator_core #(
    parameter int MAX_ORDER = bpa_pkg::MAX_ORDER_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata fields, lowest bit up: mode[0], order[4:1], page_offset[14:5]
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata fields, lowest bit up: block_offset[9:0], status[11:10]
    output logic [15:0] m_axis_tdata
);
    import bpa_pkg::*;

    localparam int NP = 1 << MAX_ORDER;
    localparam int AW = MAX_ORDER;
    localparam int OW = $clog2(MAX_ORDER + 1);
    localparam int NL = MAX_ORDER + 1;

    // Page entry: next, prev, size, allocated, head, and the flags that say
    // whether the prev and next links are valid.
    typedef struct packed {
        logic [AW-1:0] nxt;
        logic [AW-1:0] prv;
        logic [OW-1:0] size;
        logic          alloc;
        logic          head;
        logic          hp;
        logic          hn;
    } pent_t;

    pent_t mem [NP];
    pent_t rd_reg;
    logic [AW-1:0] ra, wa;
    logic          re, we;
    pent_t         wd;
    always_ff @(posedge aclk) begin
        if (we) mem[wa] <= wd;
        if (re) rd_reg <= mem[ra];
    end

    logic [AW-1:0] head_reg [NL];
    logic [NL-1:0] lv_reg;

    state_t st_reg, ret_reg;
    logic          clr_reg;
    logic [AW:0]   clr_cnt_reg;
    logic          mode_reg;
    logic [3:0]    ord_reg;
    logic [9:0]    off_reg;
    logic [AW-1:0] o_reg, b_reg, r_reg, x_reg;
    logic [OW-1:0] j_reg;
    pent_t         e_reg;     // entry being removed
    logic          second_reg; // second pass through the merge read and check
    logic          ovld_reg;
    logic [9:0]    oofs_reg;
    status_t       ost_reg;
    // Output word, kept apart so the next word can be worked on while it waits.
    logic [9:0]    m_ofs_reg;
    status_t       m_st_reg;

    assign s_axis_tready = !clr_reg && st_reg == S_IDLE;
    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = {4'd0, m_st_reg, m_ofs_reg};

    // Smallest non-empty list at or above the requested order.
    logic          fnd;
    logic [OW-1:0] fk;
    always_comb begin
        fnd = 1'b0;
        fk  = '0;
        for (int i = MAX_ORDER; i >= 0; i--)
            if (lv_reg[i] && i >= int'(ord_reg)) begin
                fnd = 1'b1;
                fk  = OW'(i);
            end
    end

    logic [AW-1:0] upa;
    assign upa = r_reg + (AW'(1) << (j_reg - OW'(1)));
    logic [AW-1:0] bud;
    assign bud = o_reg ^ (AW'(1) << rd_reg.size);

    // The sequencer drives the single RAM port; reads land in rd_reg.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            clr_reg <= 1'b1;
            clr_cnt_reg <= '0;
            lv_reg <= NL'(1) << MAX_ORDER;
            ovld_reg <= 1'b0;
            for (int i = 0; i < NL; i++) head_reg[i] <= '0;
        end else begin
            if (st_reg == S_OUT && (!ovld_reg || m_axis_tready)) ovld_reg <= 1'b1;
            else if (m_axis_tready) ovld_reg <= 1'b0;
            if (clr_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (AW+1)'(NP - 1)) clr_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    mode_reg <= s_axis_tdata[0];
                    ord_reg  <= s_axis_tdata[4:1];
                    off_reg  <= s_axis_tdata[14:5];
                    st_reg   <= S_CHECK;
                end
                S_CHECK: begin
                    if (!mode_reg) begin
                        if (int'(ord_reg) > MAX_ORDER) begin
                            ost_reg <= ST_TOO_BIG; oofs_reg <= '0; st_reg <= S_OUT;
                        end else if (!fnd) begin
                            ost_reg <= ST_OOM; oofs_reg <= '0; st_reg <= S_OUT;
                        end else begin
                            j_reg <= fk;
                            r_reg <= head_reg[fk]; x_reg <= head_reg[fk];
                            second_reg <= 1'b0; ret_reg <= S_SPLIT;
                            st_reg <= S_RM_RD;
                        end
                    end else begin
                        oofs_reg <= off_reg;
                        second_reg <= 1'b0;
                        if (int'(off_reg) >= NP) begin
                            ost_reg <= ST_IGNORED; st_reg <= S_OUT;
                        end else begin
                            o_reg <= AW'(off_reg); st_reg <= S_FREE_RD;
                        end
                    end
                end
                // Remove x_reg from its list; rd_reg holds its entry.
                S_RM_RD: begin
                    e_reg <= rd_reg;
                    if (head_reg[rd_reg.size] == x_reg) begin
                        lv_reg[rd_reg.size] <= rd_reg.hn;
                        if (rd_reg.hn) head_reg[rd_reg.size] <= rd_reg.nxt;
                        st_reg <= rd_reg.hn ? S_RM_W2 : S_RM_DONE;
                    end else st_reg <= S_RM_W1;
                end
                S_RM_W1: st_reg <= e_reg.hn ? S_RM_W2 : S_RM_DONE; // prev updated
                S_RM_W2: st_reg <= S_RM_DONE;                      // next updated
                S_RM_DONE: st_reg <= ret_reg;
                S_SPLIT: begin
                    if (j_reg > OW'(ord_reg)) begin
                        x_reg <= upa; st_reg <= S_PUSH_RD;
                    end else begin
                        ost_reg <= ST_OK; oofs_reg <= 10'(r_reg); st_reg <= S_FINISH;
                    end
                end
                S_PUSH_RD: st_reg <= S_PUSH_W; // write pushed entry
                S_PUSH_W: begin // old head linked back
                    lv_reg[j_reg - OW'(1)] <= 1'b1;
                    head_reg[j_reg - OW'(1)] <= x_reg;
                    j_reg <= j_reg - OW'(1);
                    st_reg <= S_SPLIT;
                end
                S_FREE_RD: begin
                    if (!rd_reg.alloc || !rd_reg.head) begin
                        ost_reg <= ST_IGNORED; st_reg <= S_OUT;
                    end else begin
                        j_reg <= rd_reg.size; st_reg <= S_FREE_W;
                    end
                end
                // The old head of list j is read here; the push itself lands in
                // the first S_MRG_CHK, which also moves the list head to o.
                S_FREE_W: st_reg <= S_MRG_RD;
                S_MRG_RD: st_reg <= S_MRG_CHK; // read o's entry was issued
                S_MRG_CHK: begin
                    if (!second_reg) begin
                        lv_reg[j_reg] <= 1'b1; head_reg[j_reg] <= o_reg;
                    end
                    if (second_reg) begin
                        b_reg <= bud; st_reg <= S_MRG_HI;
                    end else if (int'(j_reg) >= MAX_ORDER) begin
                        ost_reg <= ST_OK; st_reg <= S_OUT;
                    end else begin
                        b_reg <= bud; second_reg <= 1'b1; st_reg <= S_MRG_RD;
                    end
                end
                S_MRG_HI: begin
                    // rd_reg holds buddy entry
                    second_reg <= 1'b0;
                    if (!rd_reg.head || rd_reg.alloc || rd_reg.size != j_reg) begin
                        ost_reg <= ST_OK; st_reg <= S_OUT;
                    end else begin
                        x_reg <= o_reg; ret_reg <= S_FINISH; st_reg <= S_RM_RD;
                        ord_reg <= 4'd0; // used as merge phase marker
                    end
                end
                S_FINISH: begin
                    if (!mode_reg) st_reg <= S_OUT;
                    else if (ord_reg == 4'd0) begin
                        x_reg <= b_reg; ord_reg <= 4'd1; st_reg <= S_RM_RD;
                    end else if (ord_reg == 4'd1) begin
                        // hi loses head; lo grows and is pushed
                        ord_reg <= 4'd2;
                    end else if (ord_reg == 4'd2) begin
                        o_reg <= (o_reg < b_reg) ? o_reg : b_reg;
                        j_reg <= j_reg + OW'(1); ord_reg <= 4'd3;
                    end else begin
                        ord_reg <= 4'd4; st_reg <= S_FREE_W;
                        x_reg <= o_reg;
                    end
                end
                S_OUT: if (!ovld_reg || m_axis_tready) begin
                    m_st_reg <= ost_reg; m_ofs_reg <= oofs_reg; st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // RAM port control.
    always_comb begin
        re = 1'b0; ra = '0; we = 1'b0; wa = '0; wd = '0;
        if (clr_reg) begin
            we = 1'b1; wa = clr_cnt_reg[AW-1:0];
            if (clr_cnt_reg[AW-1:0] == '0) begin
                wd.head = 1'b1; wd.size = OW'(MAX_ORDER);
            end
        end else begin
            case (st_reg)
                S_CHECK: begin re = 1'b1; ra = mode_reg ? AW'(off_reg) : head_reg[fk]; end
                S_RM_RD: if (head_reg[rd_reg.size] == x_reg) begin
                    if (rd_reg.hn) begin re = 1'b1; ra = rd_reg.nxt; end
                end else begin re = 1'b1; ra = rd_reg.prv; end
                S_RM_W1: begin
                    we = 1'b1; wa = e_reg.prv; wd = rd_reg; wd.hn = e_reg.hn;
                    if (e_reg.hn) wd.nxt = e_reg.nxt;
                    re = e_reg.hn; ra = e_reg.nxt;
                end
                S_RM_W2: begin
                    we = 1'b1; wa = e_reg.nxt; wd = rd_reg;
                    if (head_reg[e_reg.size] == e_reg.nxt && !(e_reg.hp)) wd.hp = 1'b0;
                    else begin wd.hp = 1'b1; wd.prv = e_reg.prv; end
                    if (!e_reg.hp) wd.hp = 1'b0;
                end
                S_SPLIT: if (j_reg > OW'(ord_reg)) begin
                    re = 1'b1; ra = head_reg[j_reg - OW'(1)];
                end else begin
                    re = 1'b1; ra = r_reg;
                end
                S_PUSH_RD: begin
                    we = 1'b1; wa = x_reg;
                    wd.head = 1'b1; wd.size = j_reg - OW'(1);
                    wd.hn = lv_reg[j_reg - OW'(1)]; wd.nxt = head_reg[j_reg - OW'(1)];
                end
                S_PUSH_W: if (lv_reg[j_reg - OW'(1)]) begin
                    we = 1'b1; wa = head_reg[j_reg - OW'(1)];
                    wd = rd_reg; wd.hp = 1'b1; wd.prv = x_reg;
                end
                S_FREE_W: begin
                    re = 1'b1; ra = head_reg[j_reg];
                end
                S_MRG_RD: begin
                    if (!second_reg) begin
                        if (lv_reg[j_reg] && head_reg[j_reg] != o_reg) begin
                            we = 1'b1; wa = head_reg[j_reg];
                            wd = rd_reg; wd.hp = 1'b1; wd.prv = o_reg;
                        end
                    end
                    re = 1'b1; ra = o_reg;
                end
                S_MRG_CHK: begin
                    if (!second_reg) begin
                        we = 1'b1; wa = o_reg;
                        wd = rd_reg; wd.alloc = 1'b0; wd.hp = 1'b0;
                        wd.size = j_reg;
                        wd.hn = lv_reg[j_reg]; wd.nxt = head_reg[j_reg];
                    end
                    re = 1'b1; ra = bud;
                end
                S_MRG_HI: if (rd_reg.head && !rd_reg.alloc && rd_reg.size == j_reg) begin
                    re = 1'b1; ra = o_reg;
                end
                S_RM_DONE: if (ret_reg == S_SPLIT) begin
                    re = 1'b0;
                end else begin
                    re = 1'b1; ra = b_reg;
                end
                S_FINISH: begin
                    if (!mode_reg) begin
                        we = 1'b1; wa = r_reg; wd = rd_reg;
                        wd.alloc = 1'b1; wd.size = OW'(ord_reg);
                    end else if (ord_reg == 4'd0) begin
                        re = 1'b1; ra = b_reg;
                    end else if (ord_reg == 4'd1) begin
                        re = 1'b1; ra = (o_reg < b_reg) ? b_reg : o_reg;
                    end else if (ord_reg == 4'd2) begin
                        we = 1'b1; wa = (o_reg < b_reg) ? b_reg : o_reg;
                        wd = rd_reg; wd.head = 1'b0;
                        re = 1'b1; ra = (o_reg < b_reg) ? o_reg : b_reg;
                    end else begin
                        we = 1'b1; wa = o_reg; wd = rd_reg; wd.size = j_reg;
                        wd.hp = 1'b0; wd.hn = lv_reg[j_reg];
                        wd.nxt = head_reg[j_reg];
                    end
                end
                default: ;
            endcase
        end
    end

    // Output handshake, clear pass and error word checks.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped");
    a_no_accept_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_reg |-> !s_axis_tready)
        else $error("accept during clear");
    a_top_valid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ovld_reg && m_st_reg == ST_TOO_BIG |-> m_ofs_reg == '0)
        else $error("bad offset on error");
endmodule

>>> verif/buddy_page_allocator_core_test.sv
// Self-checking testbench for buddy_page_allocator_core: directed table, then
// random allocate/free traffic checked against an in-bench buddy model. Uses bpa_pkg.
module buddy_page_allocator_core_test;
    import bpa_pkg::*;

    localparam int MAXO   = MAX_ORDER_DEF;
    localparam int NPAGES = 1 << MAXO;
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic [9:0] page_offset;
        logic [3:0] order;
        logic       mode;
    } request_t;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] block_offset;
    } grant_t;

    // One page table entry of the allocator model.
    typedef struct {
        int  nxt;
        int  prv;
        int  size;
        bit  allocated;
        bit  head;
        bit  prev_ok;
        bit  next_ok;
    } page_t;

    // Directed row: request plus an optional hand-written expectation.
    typedef struct {
        request_t req;
        bit       fixed;
        grant_t   grant;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    page_t  pages [NPAGES];
    int     free_head [MAXO+1];
    bit     free_valid [MAXO+1];
    grant_t grants_due [$];
    int     held_blocks [$];
    int     mismatches = 0;
    int     results_seen = 0;
    bit     hold_off = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    buddy_page_allocator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    function automatic void model_reset();
        foreach (pages[i]) pages[i] = '{0, 0, 0, 0, 0, 0, 0};
        foreach (free_head[i]) begin
            free_head[i] = 0;
            free_valid[i] = 0;
        end
        pages[0].head = 1;
        pages[0].size = MAXO;
        free_valid[MAXO] = 1;
    endfunction

    function automatic void list_insert(int o);
        int s;
        int h;
        s = pages[o].size;
        if (s > MAXO) return;
        pages[o].prev_ok = 0;
        if (!free_valid[s]) begin
            free_valid[s] = 1;
            free_head[s] = o;
            pages[o].next_ok = 0;
        end else begin
            h = free_head[s];
            pages[o].next_ok = 1;
            pages[o].nxt = h;
            pages[h].prev_ok = 1;
            pages[h].prv = o;
            free_head[s] = o;
        end
    endfunction

    function automatic void list_unlink(int o);
        int s;
        int p;
        int n;
        s = pages[o].size;
        if (s > MAXO) return;
        if (free_head[s] == o) begin
            free_valid[s] = pages[o].next_ok;
            if (pages[o].next_ok) begin
                free_head[s] = pages[o].nxt;
                pages[pages[o].nxt].prev_ok = 0;
            end
        end else begin
            p = pages[o].prv;
            pages[p].next_ok = pages[o].next_ok;
            if (pages[o].next_ok) begin
                n = pages[o].nxt;
                pages[p].nxt = n;
                pages[n].prev_ok = 1;
                pages[n].prv = p;
            end
        end
    endfunction

    // Computes the grant for one request and updates the allocator model.
    function automatic grant_t allocate_or_release(request_t rq);
        grant_t g;
        int k;
        int r;
        int up;
        int o;
        int s;
        int b;
        int lo;
        int hi;
        g = '0;
        if (rq.mode == MODE_ALLOC) begin
            if (rq.order > MAXO) begin
                g.status = ST_TOO_BIG;
                return g;
            end
            for (k = rq.order; k <= MAXO; k++) if (free_valid[k]) break;
            if (k > MAXO) begin
                g.status = ST_OOM;
                return g;
            end
            r = free_head[k];
            list_unlink(r);
            for (int j = k; j > rq.order; j--) begin
                up = (r + (1 << (j - 1))) % NPAGES;
                pages[up].allocated = 0;
                pages[up].head = 1;
                pages[up].size = j - 1;
                pages[r].size = j - 1;
                list_insert(up);
            end
            pages[r].allocated = 1;
            g.block_offset = 10'(r);
            g.status = ST_OK;
        end else begin
            g.block_offset = rq.page_offset;
            o = rq.page_offset;
            if (o >= NPAGES || !pages[o].allocated || !pages[o].head) begin
                g.status = ST_IGNORED;
                return g;
            end
            pages[o].allocated = 0;
            list_insert(o);
            while (pages[o].size < MAXO) begin
                s = pages[o].size;
                b = (o ^ (1 << s)) % NPAGES;
                if (!pages[b].head || pages[b].allocated || pages[b].size != s) break;
                list_unlink(o);
                list_unlink(b);
                lo = (o < b) ? o : b;
                hi = (o < b) ? b : o;
                pages[hi].head = 0;
                pages[lo].size = s + 1;
                list_insert(lo);
                o = lo;
            end
            g.status = ST_OK;
        end
        return g;
    endfunction

    // Offers one word with a random lead-in gap and waits for its acceptance.
    // Valid stays high after acceptance so that a gapless next word follows on.
    task automatic send_word(request_t rq, bit fixed, grant_t want);
        int gap;
        grant_t g;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, rq};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        // The model is updated at acceptance, in request order.
        g = allocate_or_release(rq);
        if (fixed && g != want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with model: row %h model %h", want, g);
        end
        grants_due.push_back(g);
        if (rq.mode == MODE_ALLOC && g.status == ST_OK) held_blocks.push_back(g.block_offset);
    endtask

    function automatic request_t make_req(logic mode, int order, int offset);
        request_t rq;
        rq.mode = mode;
        rq.order = 4'(order);
        rq.page_offset = 10'(offset);
        return rq;
    endfunction

    // Receiver: random stalls per word, plus a long hold-off when requested.
    initial begin
        int stall;
        grant_t got;
        grant_t want;
        @(posedge aresetn);
        forever begin
            stall = $urandom_range(0, 11);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0 || hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
                while (hold_off) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            got = m_axis_tdata[11:0];
            results_seen++;
            if (grants_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
            end else begin
                want = grants_due.pop_front();
                if (got.block_offset !== want.block_offset || got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected offset %0d status %0d, got offset %0d status %0d",
                                 want.block_offset, want.status, got.block_offset, got.status);
                end
            end
        end
    end

    // Long receiver stall, counted in its own process, to back up the block.
    initial begin
        wait (results_seen >= 60);
        hold_off = 1;
        repeat (600) @(posedge aclk);
        hold_off = 0;
    end

    initial begin
        row_t rows [$];
        int idx;
        int ord;
        rows = '{
            '{make_req(MODE_ALLOC, 15, 0), 1, '{ST_TOO_BIG, 10'd0}},
            '{make_req(MODE_ALLOC, 11, 1023), 1, '{ST_TOO_BIG, 10'd0}},
            '{make_req(MODE_FREE, 0, 1023), 1, '{ST_IGNORED, 10'd1023}},
            '{make_req(MODE_FREE, 15, 0), 1, '{ST_IGNORED, 10'd0}},
            '{make_req(MODE_ALLOC, 10, 0), 1, '{ST_OK, 10'd0}},
            '{make_req(MODE_ALLOC, 0, 0), 1, '{ST_OOM, 10'd0}},
            '{make_req(MODE_FREE, 0, 0), 1, '{ST_OK, 10'd0}},
            '{make_req(MODE_ALLOC, 0, 0), 1, '{ST_OK, 10'd0}},
            '{make_req(MODE_ALLOC, 0, 0), 0, '0},
            '{make_req(MODE_ALLOC, 3, 0), 0, '0},
            '{make_req(MODE_ALLOC, 9, 0), 0, '0},
            '{make_req(MODE_FREE, 0, 1), 0, '0},
            '{make_req(MODE_FREE, 0, 1), 0, '0},
            '{make_req(MODE_FREE, 0, 2), 0, '0},
            '{make_req(MODE_FREE, 0, 0), 0, '0},
            '{make_req(MODE_FREE, 0, 8), 0, '0},
            '{make_req(MODE_FREE, 0, 512), 0, '0},
            '{make_req(MODE_ALLOC, 10, 0), 1, '{ST_OK, 10'd0}},
            '{make_req(MODE_FREE, 0, 0), 1, '{ST_OK, 10'd0}}
        };
        model_reset();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (rows[i]) send_word(rows[i].req, rows[i].fixed, rows[i].grant);
        held_blocks.delete();
        // Random part: half valid frees of held blocks, the rest allocations (small orders mostly) and random frees.
        for (int n = 0; n < 530; n++) begin
            case ($urandom_range(0, 9)) inside
                [0:3]: begin
                    ord = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(0, 4);
                    send_word(make_req(MODE_ALLOC, ord, $urandom_range(0, 1023)), 0, '0);
                end
                [4:8]: begin
                    if (held_blocks.size() > 0) begin
                        idx = $urandom_range(0, held_blocks.size() - 1);
                        send_word(make_req(MODE_FREE, $urandom_range(0, 15),
                                           held_blocks[idx]), 0, '0);
                        held_blocks.delete(idx);
                    end else begin
                        send_word(make_req(MODE_ALLOC, 0, 0), 0, '0);
                    end
                end
                default:
                    send_word(make_req(MODE_FREE, $urandom_range(0, 15),
                                       $urandom_range(0, 1023)), 0, '0);
            endcase
        end
        s_axis_tvalid <= 1'b0;
        wait (grants_due.size() == 0);
        repeat (200) @(posedge aclk);
        $display("Ran directed table and 530 random allocate/free words, %0d results checked.",
                 results_seen);
        if (mismatches == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #10000000;
        $display("Timed out waiting for results.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
